FILE: hdl/fpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared widths, codes, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fpp_pkg;

    localparam int TIME_W = 63;
    localparam int FID_W  = 32;
    localparam int CFG_W  = 30;
    localparam int SLOP_W = 19;
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 3;
    localparam int PH_W   = 3;
    localparam int CNT_W  = 5;

    localparam int IN_W   = 288;
    localparam int OUT_W  = 272;

    localparam int DEF_RING_DEPTH = 16;
    localparam int DEF_IDENT_BITS = 32;

    localparam logic [SLOP_W-1:0] HALF_MS_NS = SLOP_W'(500000);
    localparam int CLEAN_PERIODS = 10;

    localparam logic [CNT_W-1:0] LAST_STEP = '1;
    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(1);

    localparam logic [ACT_W-1:0] ACT_PREDICT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WAKE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BEGIN   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUBMIT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INFO    = 3'd4;

    localparam logic [PH_W-1:0] PH_CLEARED   = 3'd0;
    localparam logic [PH_W-1:0] PH_PREDICTED = 3'd1;
    localparam logic [PH_W-1:0] PH_SUBMITTED = 3'd4;
    localparam logic [PH_W-1:0] PH_DONE      = 3'd5;

    localparam logic [IDX_W-1:0] REG_FRAME_PERIOD   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESENT_OFFSET = 3'd1;
    localparam logic [IDX_W-1:0] REG_BUDGET_START   = 3'd2;
    localparam logic [IDX_W-1:0] REG_BUDGET_MAX     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MISS_STEP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_TUNE_STEP      = 3'd5;
    localparam logic [IDX_W-1:0] REG_TARGET_MARGIN  = 3'd6;

    localparam logic [CFG_W-1:0] RST_FRAME_PERIOD   = CFG_W'(16666666);
    localparam logic [CFG_W-1:0] RST_PRESENT_OFFSET = CFG_W'(4000000);
    localparam logic [CFG_W-1:0] RST_BUDGET_START   = CFG_W'(6666666);
    localparam logic [CFG_W-1:0] RST_BUDGET_MAX     = CFG_W'(13333333);
    localparam logic [CFG_W-1:0] RST_MISS_STEP      = CFG_W'(1666666);
    localparam logic [CFG_W-1:0] RST_TUNE_STEP      = CFG_W'(333333);
    localparam logic [CFG_W-1:0] RST_TARGET_MARGIN  = CFG_W'(1333333);

    typedef struct packed {
        logic load;
        logic mod_step;
        logic scan_start;
        logic scan_step;
        logic rd_pred;
        logic calc_start;
        logic calc_tgt;
        logic div_step;
        logic div_fin;
        logic rd_info;
        logic info_exec;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_predict;
        logic is_item;
        logic scan_done;
        logic clean;
        logic need_div;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/fpp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_ctrl
// Sequencer for predict, mark and info items.
// ----------------------------------------------------------------------------
module fpp_ctrl
    import fpp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC  = 4'd1;
    localparam logic [3:0] ST_MOD  = 4'd2;
    localparam logic [3:0] ST_SCAN = 4'd3;
    localparam logic [3:0] ST_RDP  = 4'd4;
    localparam logic [3:0] ST_CST  = 4'd5;
    localparam logic [3:0] ST_CTG  = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_DFN  = 4'd8;
    localparam logic [3:0] ST_RDI  = 4'd9;
    localparam logic [3:0] ST_IEX  = 4'd10;
    localparam logic [3:0] ST_CMT  = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cnt_next = '0;
                if (sts.is_predict) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else if (sts.is_item) begin
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_CMT;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MOD_LAST) state_next = ST_RDI;
            end
            ST_SCAN: begin
                if (sts.scan_done) state_next = ST_RDP;
                else cmd.scan_step = 1'b1;
            end
            ST_RDP: begin
                cmd.rd_pred = 1'b1;
                state_next  = ST_CST;
            end
            ST_CST: begin
                cmd.calc_start = 1'b1;
                state_next     = sts.clean ? ST_CMT : ST_CTG;
            end
            ST_CTG: begin
                cmd.calc_tgt = 1'b1;
                cnt_next     = '0;
                state_next   = sts.need_div ? ST_DIV : ST_CMT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) state_next = ST_DFN;
            end
            ST_DFN: begin
                cmd.div_fin = 1'b1;
                state_next  = ST_CMT;
            end
            ST_RDI: begin
                cmd.rd_info = 1'b1;
                state_next  = ST_IEX;
            end
            ST_IEX: begin
                cmd.info_exec = 1'b1;
                state_next    = ST_CMT;
            end
            ST_CMT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: hdl/fpp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_dp
// Frame ring, render budget, remainder unit and result register.
// ----------------------------------------------------------------------------
module fpp_dp
    import fpp_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int IDENT_BITS = DEF_IDENT_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             cfg_valid,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  cmd_t             cmd,
    output sts_t             sts
);

    localparam int SW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH) + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(RING_DEPTH);
    localparam logic [63:0]   ID_MASK   = (64'd1 << IDENT_BITS) - 64'd1;

    // reciprocal of the ring depth, exact for every 32-bit frame number
    localparam int          ML      = $clog2(RING_DEPTH);
    localparam logic [63:0] RECIP64 =
        ((64'd1 << (FID_W + ML)) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [FID_W:0] RECIP = RECIP64[FID_W:0];

    typedef logic [TIME_W-1:0] time_t;

    // configuration
    logic [CFG_W-1:0] fp_reg, off_reg, bmax_reg, ms_reg, ts_reg, tm_reg;
    time_t            budget_reg;

    // item
    logic [ACT_W-1:0] act_reg;
    time_t            now_reg, ap_reg, ep_reg, gm_reg;
    logic [FID_W-1:0] fid_reg;
    logic [FID_W-1:0] q_reg;
    logic [SW-1:0]    rem_reg;

    // ring
    logic [PH_W-1:0]       phase_reg [RING_DEPTH];
    time_t                 tmem [RING_DEPTH];
    time_t                 dmem [RING_DEPTH];
    time_t                 emem [RING_DEPTH];
    logic [IDENT_BITS-1:0] nid_reg;
    logic [SW-1:0]         nslot_reg;

    // scan
    logic [CW-1:0] scnt_reg, pcnt_reg, ccnt_reg;
    logic [SW-1:0] sslot_reg, pslot_reg, cslot_reg;
    logic          pf_reg, cf_reg;

    // step
    time_t            ear_q, disp_q, tq_reg, start_reg, tgt_reg, from_reg;
    logic [63:0]      div_reg;
    logic [CFG_W-1:0] r_reg;

    // info
    logic  miss_reg, dge_reg, mgt_reg;
    time_t bsat_reg, dec_reg, inc_reg;

    // result
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_reg;

    logic [CFG_W-1:0] per;
    logic             scan_act;
    logic [PH_W-1:0]  sph, iph;
    logic [SW-1:0]    islot;

    assign per      = (fp_reg == '0) ? CFG_W'(1) : fp_reg;
    assign scan_act = (scnt_reg < DEPTH_C) &&
                      (64'(nid_reg) >= 64'(scnt_reg));
    assign sph      = phase_reg[sslot_reg];
    assign islot    = rem_reg;
    assign iph      = phase_reg[islot];

    assign sts.is_predict = (act_reg == ACT_PREDICT);
    assign sts.is_item    = (act_reg == ACT_WAKE) || (act_reg == ACT_BEGIN) ||
                            (act_reg == ACT_SUBMIT) || (act_reg == ACT_INFO);
    assign sts.scan_done  = !scan_act || cf_reg;
    assign sts.clean      = !pf_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

    // step arithmetic
    time_t             tgt0, from_c;
    logic [CW-1:0]     gap;
    logic [CW+29:0]    gprod;
    time_t             fp_x10;
    assign tgt0   = start_reg + TIME_W'(per);
    assign from_c = now_reg + budget_reg;
    assign sts.need_div = !(tgt0 > from_c);
    assign gap    = ccnt_reg - pcnt_reg;
    assign gprod  = (CW+30)'(gap) * (CW+30)'(fp_reg);
    assign fp_x10 = (TIME_W'(fp_reg) << 3) + (TIME_W'(fp_reg) << 1);

    // remainder, two bits per step
    logic [CFG_W:0]   t1, t2;
    logic [CFG_W-1:0] r1, r2;
    always_comb begin
        t1 = {r_reg, div_reg[63]};
        r1 = (t1 >= {1'b0, per}) ? CFG_W'(t1 - {1'b0, per}) : t1[CFG_W-1:0];
        t2 = {r1, div_reg[62]};
        r2 = (t2 >= {1'b0, per}) ? CFG_W'(t2 - {1'b0, per}) : t2[CFG_W-1:0];
    end

    // slot of the frame number: quotient, then remainder
    logic [2*FID_W:0] mprod;
    logic [FID_W-1:0] qd, rfull;
    assign mprod = (2*FID_W+1)'(fid_reg) * (2*FID_W+1)'(RECIP);
    assign qd    = q_reg * FID_W'(RING_DEPTH);
    assign rfull = fid_reg - qd;

    // info arithmetic
    logic [63:0] s_miss, s_tune;
    time_t       dmar;
    assign s_miss = 64'(budget_reg) + 64'(ms_reg);
    assign s_tune = 64'(budget_reg) + 64'(ts_reg);
    assign dmar   = (gm_reg >= TIME_W'(tm_reg)) ? gm_reg - TIME_W'(tm_reg)
                                                : TIME_W'(tm_reg) - gm_reg;

    // commit values
    time_t disp_c, wake_c, bmin_c, bnew_c;
    logic  mark_ok, info_ok, item_err;
    logic [63:0] nid64;
    assign disp_c  = tgt_reg + TIME_W'(off_reg);
    assign wake_c  = tgt_reg - budget_reg;
    assign bmin_c  = (bsat_reg > TIME_W'(bmax_reg)) ? TIME_W'(bmax_reg) : bsat_reg;
    assign bnew_c  = miss_reg ? bmin_c : (dge_reg ? (mgt_reg ? dec_reg : inc_reg)
                                                  : budget_reg);
    assign mark_ok = (iph == act_reg);
    assign info_ok = (iph == PH_SUBMITTED);
    assign item_err = (act_reg == ACT_INFO) ? !info_ok : !(sts.is_item && mark_ok);
    assign nid64   = 64'(nid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_reg        <= RST_FRAME_PERIOD;
            off_reg       <= RST_PRESENT_OFFSET;
            bmax_reg      <= RST_BUDGET_MAX;
            ms_reg        <= RST_MISS_STEP;
            ts_reg        <= RST_TUNE_STEP;
            tm_reg        <= RST_TARGET_MARGIN;
            budget_reg    <= TIME_W'(RST_BUDGET_START);
            nid_reg       <= '0;
            nslot_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) phase_reg[i] <= PH_CLEARED;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_FRAME_PERIOD:   fp_reg   <= cfg_data;
                    REG_PRESENT_OFFSET: off_reg  <= cfg_data;
                    REG_BUDGET_START:   budget_reg <= TIME_W'(cfg_data);
                    REG_BUDGET_MAX:     bmax_reg <= cfg_data;
                    REG_MISS_STEP:      ms_reg   <= cfg_data;
                    REG_TUNE_STEP:      ts_reg   <= cfg_data;
                    REG_TARGET_MARGIN:  tm_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.commit) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            if (cmd.commit) begin
                if (act_reg == ACT_PREDICT) begin
                    phase_reg[nslot_reg] <= PH_PREDICTED;
                    nid_reg <= nid_reg + 1'b1;
                    if (&nid_reg || nslot_reg == LAST_SLOT) nslot_reg <= '0;
                    else nslot_reg <= nslot_reg + 1'b1;
                end else if (act_reg == ACT_INFO) begin
                    if (info_ok) begin
                        phase_reg[islot] <= PH_DONE;
                        budget_reg       <= bnew_c;
                    end
                end else if (sts.is_item && mark_ok) begin
                    phase_reg[islot] <= act_reg + 1'b1;
                end
            end
        end
    end

    // payload and memories
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= s_tdata[2:0];
            now_reg <= s_tdata[65:3];
            fid_reg <= FID_W'(64'(s_tdata[97:66]) & ID_MASK);
            ap_reg  <= s_tdata[160:98];
            ep_reg  <= s_tdata[223:161];
            gm_reg  <= s_tdata[286:224];
            rem_reg <= '0;
        end
        if (cmd.mod_step) begin
            q_reg   <= FID_W'(mprod >> (FID_W + ML));
            rem_reg <= rfull[SW-1:0];
        end
        if (cmd.scan_start) begin
            scnt_reg  <= CW'(1);
            sslot_reg <= (nslot_reg == '0) ? LAST_SLOT : nslot_reg - 1'b1;
            pf_reg    <= 1'b0;
            cf_reg    <= 1'b0;
        end
        if (cmd.scan_step) begin
            if (!pf_reg && sph != PH_CLEARED) begin
                pf_reg    <= 1'b1;
                pcnt_reg  <= scnt_reg;
                pslot_reg <= sslot_reg;
            end
            if (sph == PH_DONE) begin
                cf_reg    <= 1'b1;
                ccnt_reg  <= scnt_reg;
                cslot_reg <= sslot_reg;
            end
            scnt_reg  <= scnt_reg + 1'b1;
            sslot_reg <= (sslot_reg == '0) ? LAST_SLOT : sslot_reg - 1'b1;
        end
        if (cmd.rd_pred) begin
            ear_q  <= emem[cslot_reg];
            disp_q <= dmem[pslot_reg];
        end
        if (cmd.calc_start) begin
            if (!pf_reg) tgt_reg <= now_reg + fp_x10;
            if (cf_reg && pcnt_reg == ccnt_reg) start_reg <= ear_q;
            else if (cf_reg) start_reg <= ear_q + TIME_W'(gprod);
            else start_reg <= disp_q;
        end
        if (cmd.calc_tgt) begin
            tgt_reg  <= tgt0;
            from_reg <= from_c;
            div_reg  <= 64'(from_c - tgt0);
            r_reg    <= '0;
        end
        if (cmd.div_step) begin
            r_reg   <= r2;
            div_reg <= {div_reg[61:0], 2'b00};
        end
        if (cmd.div_fin) tgt_reg <= from_reg - TIME_W'(r_reg) + TIME_W'(per);
        if (cmd.rd_info) tq_reg <= tmem[islot];
        if (cmd.info_exec) begin
            miss_reg <= (ap_reg > tq_reg) && ((ap_reg - tq_reg) >= TIME_W'(HALF_MS_NS));
            bsat_reg <= s_miss[63] ? '1 : s_miss[TIME_W-1:0];
            inc_reg  <= s_tune[63] ? '1 : s_tune[TIME_W-1:0];
            dec_reg  <= (budget_reg > TIME_W'(ts_reg)) ? budget_reg - TIME_W'(ts_reg)
                                                       : '0;
            dge_reg  <= (dmar >= TIME_W'(ts_reg));
            mgt_reg  <= (gm_reg > TIME_W'(tm_reg));
        end
        if (cmd.commit) begin
            if (act_reg == ACT_PREDICT) begin
                tmem[nslot_reg] <= tgt_reg;
                dmem[nslot_reg] <= disp_c;
                out_reg <= {1'b0, fp_reg, HALF_MS_NS, disp_c, tgt_reg, wake_c,
                            nid64[31:0], 1'b0};
            end else begin
                out_reg <= {{(OUT_W-1){1'b0}}, item_err};
                if (act_reg == ACT_INFO && info_ok) emem[islot] <= ep_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> (scnt_reg < DEPTH_C))
        else $error("scan past ring");
    a_nid_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && act_reg == ACT_PREDICT) |=>
        (nid_reg == IDENT_BITS'($past(nid_reg) + 1'b1)))
        else $error("frame number not advanced");

endmodule

FILE: hdl/frame_pacing_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacing_predictor
// Frame pacing predictor: ring of frame records and adaptive render budget.
// ----------------------------------------------------------------------------
// One item is processed at a time; a finished result waits in an output
// register while the next item is accepted. Mark and info items pass through
// decode, the steps of the reciprocal multiply that maps the frame number to
// its ring slot, the target read, the info step and commit. A predict item
// scans up to RING_DEPTH-1 ring entries, skips the target step on a clean
// slate, and runs the two-bit-per-cycle remainder unit dividing by the frame
// period when the target must be stepped forward. Unknown actions go from
// decode straight to commit. Every item waits further while the previous
// result is still held in the output register.
// ----------------------------------------------------------------------------
module frame_pacing_predictor
    import fpp_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int IDENT_BITS = DEF_IDENT_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // action[2:0], time_now[65:3], frame_ident[97:66], actual_present[160:98],
    // earliest_present[223:161], gpu_margin[286:224]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[0], new_frame[32:1], wake_time[95:33], target_present[158:96],
    // display_estimate[221:159], present_slop[240:222], display_period[270:241]
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpp_dp #(
        .RING_DEPTH (RING_DEPTH),
        .IDENT_BITS (IDENT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
